// File: hdl/phts_pkg.sv
// ----------------------------------------------------------------------------
// Path hash table search package
// Shared types, mode codes and CRC-32 constants for the path hash lookup.
// ----------------------------------------------------------------------------
package phts_pkg;

  // Item modes.
  localparam logic [1:0] MODE_WRITE  = 2'd0;
  localparam logic [1:0] MODE_BYTE   = 2'd1;
  localparam logic [1:0] MODE_SEARCH = 2'd2;
  localparam logic [1:0] MODE_NONE   = 2'd3;

  // Reflected CRC-32.
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  // Name normalization constants.
  localparam logic [7:0] NAME_SLASH     = 8'h2F;
  localparam logic [7:0] NAME_BACKSLASH = 8'h5C;
  localparam logic [7:0] HIGH_BYTES     = 8'h80;
  localparam logic [7:0] UPPER_FIRST    = 8'h41;
  localparam logic [7:0] UPPER_LAST     = 8'h5A;
  localparam logic [7:0] CASE_OFFSET    = 8'h20;

  typedef logic [10:0] count_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [9:0]  entry_index;
    logic [31:0] entry_hash;
    logic [7:0]  name_byte;
  } req_t;

  typedef struct packed {
    logic        found;
    logic [9:0]  match_index;
    logic [31:0] name_hash;
  } rsp_t;

  // Outcome of one binary search.
  typedef struct packed {
    logic        found;
    logic [10:0] index;
  } srch_res_t;

  // Lower case for ASCII letters, slash to backslash, high bytes unchanged.
  function automatic logic [7:0] normalize_byte(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b < HIGH_BYTES) begin
      if (b == NAME_SLASH) begin
        r = NAME_BACKSLASH;
      end else if (b >= UPPER_FIRST && b <= UPPER_LAST) begin
        r = b + CASE_OFFSET;
      end
    end
    return r;
  endfunction

endpackage

// File: hdl/phts_stream_if.sv
// ----------------------------------------------------------------------------
// Stream channel
// Valid/ready channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
interface phts_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: hdl/phts_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module phts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/phts_crc.sv
// ----------------------------------------------------------------------------
// Bit-serial CRC-32 unit
// Folds one normalized byte into the running CRC, one bit per cycle.
// ----------------------------------------------------------------------------
module phts_crc import phts_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [7:0]  byte_in,
  input  logic        clear,
  output logic        busy,
  output logic [31:0] crc
);

  logic [2:0]  bit_cnt;
  logic [31:0] crc_shift;

  // One step of the shared shift-and-xor unit.
  assign crc_shift = (crc >> 1) ^ (crc[0] ? CRC_POLY : 32'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      crc     <= CRC_INIT;
      busy    <= 1'b0;
      bit_cnt <= 3'd0;
    end else if (clear) begin
      crc  <= CRC_INIT;
      busy <= 1'b0;
    end else if (start) begin
      crc     <= crc ^ {24'd0, normalize_byte(byte_in)};
      busy    <= 1'b1;
      bit_cnt <= 3'd0;
    end else if (busy) begin
      crc     <= crc_shift;
      bit_cnt <= bit_cnt + 3'd1;
      if (bit_cnt == 3'd7) begin
        busy <= 1'b0;
      end
    end
  end

  a_last_bit_ends : assert property (@(posedge clk) disable iff (rst)
    (busy && bit_cnt == 3'd7 && !clear) |=> !busy)
    else $error("CRC unit stayed busy after the eighth bit");

endmodule

// File: hdl/phts_search.sv
// ----------------------------------------------------------------------------
// Binary search sequencer
// Probes the sorted hash table with floor midpoints through one comparator.
// ----------------------------------------------------------------------------
module phts_search import phts_pkg::*; #(
  parameter int TABLE_DEPTH = 1024,
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  count_t        count,
  input  logic [31:0]   key,
  output logic          rd_en,
  output logic [AW-1:0] rd_addr,
  input  logic [31:0]   rd_data,
  output logic          done,
  output srch_res_t     result
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_PROBE = 3'b010,
    S_CMP   = 3'b100
  } srch_state_t;

  localparam logic [16:0] DEPTH_W = 17'(TABLE_DEPTH);

  srch_state_t state;
  logic [11:0] lo;
  logic [11:0] hi_x;     // exclusive upper bound
  logic [10:0] mid;
  logic [31:0] key_q;
  logic [11:0] n_lim;
  logic [12:0] mid_sum;
  logic [10:0] mid_calc;

  // Entry counts beyond the table are clamped to its depth.
  assign n_lim    = (17'(count) > DEPTH_W) ? DEPTH_W[11:0] : {1'b0, count};
  assign mid_sum  = 13'(lo) + 13'(hi_x) - 13'd1;
  assign mid_calc = mid_sum[11:1];

  assign rd_en   = (state == S_PROBE) && (lo < hi_x);
  assign rd_addr = AW'(mid_calc);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      lo    <= 12'd0;
      hi_x  <= 12'd0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            lo    <= 12'd0;
            hi_x  <= n_lim;
            state <= S_PROBE;
          end
        end
        S_PROBE: begin
          if (lo < hi_x) begin
            state <= S_CMP;
          end else begin
            done  <= 1'b1;
            lo    <= 12'd0;
            hi_x  <= 12'd0;
            state <= S_IDLE;
          end
        end
        S_CMP: begin
          if (rd_data == key_q) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else if (rd_data < key_q) begin
            lo    <= {1'b0, mid} + 12'd1;
            state <= S_PROBE;
          end else begin
            hi_x  <= {1'b0, mid};
            state <= S_PROBE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Payload registers: key, midpoint and outcome.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      key_q <= key;
    end
    if (rd_en) begin
      mid <= mid_calc;
    end
    if (state == S_PROBE && !(lo < hi_x)) begin
      result <= '{found: 1'b0, index: 11'd0};
    end else if (state == S_CMP && rd_data == key_q) begin
      result <= '{found: 1'b1, index: mid};
    end
  end

  a_cmp_range : assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP) |-> (lo < hi_x))
    else $error("Comparison with an empty search range");

  a_done_pulse : assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("Search done held for more than one cycle");

  a_hit_in_range : assert property (@(posedge clk) disable iff (rst)
    (done && result.found) |-> ({1'b0, result.index} >= lo && {1'b0, result.index} < hi_x))
    else $error("Hit index outside the search range");

endmodule

// File: hdl/path_hash_table_search.sv
// ----------------------------------------------------------------------------
// Path hash table search
// Hashes path names with CRC-32 and looks them up in a sorted hash table.
// ----------------------------------------------------------------------------
//
//   Channel | Role   | Payload                                    | Handshake
//   --------+--------+--------------------------------------------+-----------
//   req     | sink   | mode, entry_index, entry_hash, name_byte   | valid/ready
//   rsp     | source | found, match_index, name_hash              | valid/ready
//   cfg     | sink   | entry_count (11 bits)                      | valid/ready
//
// A table write item is written as it is accepted. For a path byte item the
// byte is folded into the CRC one bit per cycle by the shift unit in phts_crc.
// An end-of-name item runs the binary search; each probe is one RAM read with
// registered data followed by one compare. Reset is synchronous and needs no
// clearing pass; table entries are valid only once written. req is stalled
// while an item is in progress, and a search result waits in the rsp
// register until it is taken. cfg is always ready and must only be written
// while the block is idle.
// ----------------------------------------------------------------------------
module path_hash_table_search import phts_pkg::*; #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  phts_stream_if.sink          req,
  phts_stream_if.source        rsp,
  phts_stream_if.sink          cfg
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [16:0] DEPTH_W = 17'(TABLE_DEPTH);

  // Top-level sequencer states.
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CRC  = 4'b0010,
    S_SRCH = 4'b0100,
    S_OUT  = 4'b1000
  } top_state_t;

  top_state_t    state;
  top_state_t    state_next;
  count_t        entry_count;
  logic          rsp_valid;
  rsp_t          rsp_payload;

  req_t          req_item;
  logic          req_fire;
  logic          ram_we;
  logic          crc_start;
  logic          crc_busy;
  logic [31:0]   crc_value;
  logic          srch_start;
  logic          srch_done;
  srch_res_t     srch_res;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [31:0]   ram_rdata;
  logic          rsp_load;

  assign req_item  = req.payload;
  assign req.ready = (state == S_IDLE);
  assign req_fire  = req.valid && req.ready;

  // Table writes land directly; slots beyond the table depth are dropped.
  assign ram_we = req_fire && (req_item.mode == MODE_WRITE) &&
                  (17'(req_item.entry_index) < DEPTH_W);

  // A zero byte cannot appear in a name and leaves the CRC alone.
  assign crc_start  = req_fire && (req_item.mode == MODE_BYTE) &&
                      (req_item.name_byte != 8'd0);
  assign srch_start = req_fire && (req_item.mode == MODE_SEARCH);

  // The result leaves once the output register is free; the CRC then restarts.
  assign rsp_load = (state == S_OUT) && (!rsp_valid || rsp.ready);

  assign cfg.ready   = 1'b1;
  assign rsp.valid   = rsp_valid;
  assign rsp.payload = rsp_payload;

  phts_ram #(
    .WIDTH (32),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(req_item.entry_index)),
    .wdata (req_item.entry_hash),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  phts_crc u_crc (
    .clk     (clk),
    .rst     (rst),
    .start   (crc_start),
    .byte_in (req_item.name_byte),
    .clear   (rsp_load),
    .busy    (crc_busy),
    .crc     (crc_value)
  );

  // The final hash is the inverted running CRC.
  phts_search #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_search (
    .clk     (clk),
    .rst     (rst),
    .start   (srch_start),
    .count   (entry_count),
    .key     (~crc_value),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata),
    .done    (srch_done),
    .result  (srch_res)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (crc_start) begin
          state_next = S_CRC;
        end else if (srch_start) begin
          state_next = S_SRCH;
        end
      end
      S_CRC: begin
        if (!crc_busy) begin
          state_next = S_IDLE;
        end
      end
      S_SRCH: begin
        if (srch_done) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (rsp_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.valid) begin
        entry_count <= cfg.payload;
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Result payload; the search index is cut to the port width.
  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp_payload.found       <= srch_res.found;
      rsp_payload.match_index <= srch_res.index[9:0];
      rsp_payload.name_hash   <= ~crc_value;
    end
  end

  a_rsp_from_out : assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == S_OUT))
    else $error("Result presented without a finished search");

  a_crc_quiet : assert property (@(posedge clk) disable iff (rst)
    (state == S_SRCH || state == S_OUT) |-> !crc_busy)
    else $error("CRC changing while its hash is in use");

  a_done_in_srch : assert property (@(posedge clk) disable iff (rst)
    srch_done |-> (state == S_SRCH))
    else $error("Search finished outside the search state");

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Path hash table search testbench
// Loads sorted and unsorted hash tables, streams path names byte by byte and
// checks every lookup result against a predicted table, CRC and search.
// ----------------------------------------------------------------------------
module tb_top;
  import phts_pkg::*;

  localparam int DEPTH = 1024;
  // The slowest item is a search over the full table: 11 probes, each a RAM
  // read and a compare, plus overhead. This is rounded up generously.
  localparam int SETTLE_CYCLES = 32;
  // Length of the receiver's long hold-off, in cycles.
  localparam int HOLD_CYCLES = 400;
  // Cycles without any accepted item before the run is declared hung.
  localparam int STALL_LIMIT = 4000;
  localparam count_t COUNT_MAX = 11'h7FF;
  // Input items counted per idling setting in the random part.
  localparam int SETTING_ITEMS = 60;

  logic clk = 1'b0;
  logic rst = 1'b1;

  phts_stream_if #(.payload_t(req_t))   req_if ();
  phts_stream_if #(.payload_t(rsp_t))   rsp_if ();
  phts_stream_if #(.payload_t(count_t)) cfg_if ();

  path_hash_table_search #(
    .TABLE_DEPTH(DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if),
    .cfg(cfg_if)
  );

  always #6 clk = ~clk;

  // --------------------------------------------------------------------------
  // Predicted state of the block. It is updated at the clock edge where an
  // item or a register write is accepted, so it follows the order in which
  // the block itself sees them.
  // --------------------------------------------------------------------------
  logic [31:0] hash_image [DEPTH];
  logic [31:0] path_crc = CRC_INIT;
  count_t      live_count = '0;

  // Stimulus queues filled by the sequence below, and the lookup results
  // that are still owed by the block, oldest first.
  req_t   item_q[$];
  count_t count_q[$];
  rsp_t   lookup_q[$];

  // Idling percentages and the long hold-off request, written at falling
  // edges and read at rising edges.
  int sender_idle_pct = 20;
  int recv_idle_pct = 88;
  int hold_order = 0;

  int fails = 0;
  int setting_items = 0;
  // Entries 0 .. written_top-1 have all been written at least once; the
  // entry count is never set so that a search could probe beyond them.
  int written_top = 0;

  // Path names created by the sequence: their bytes, where each one starts,
  // how long it is and its final hash.
  logic [7:0]  name_bytes[$];
  int          name_at[$];
  int          name_len[$];
  logic [31:0] name_sum[$];

  // Characters at the borders of the case folding and the high byte range,
  // plus both slashes and the NUL that the block must skip.
  logic [7:0] corner_bytes [13] = '{8'h41, 8'h5A, 8'h40, 8'h5B, 8'h60, 8'h7B,
                                    8'h2F, 8'h5C, 8'h7F, 8'h80, 8'hFF, 8'h00,
                                    8'h01};

  // Folds one path character into a reflected CRC-32, after lower-casing
  // ASCII letters and turning a forward slash into a backslash.
  function automatic logic [31:0] fold_path_byte(logic [31:0] crc, logic [7:0] raw);
    logic [7:0] c;
    c = raw;
    if (raw < HIGH_BYTES) begin
      if (raw == NAME_SLASH) begin
        c = NAME_BACKSLASH;
      end else if (raw >= UPPER_FIRST && raw <= UPPER_LAST) begin
        c = raw | CASE_OFFSET;
      end
    end
    crc = crc ^ {24'd0, c};
    for (int k = 0; k < 8; k++) begin
      crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
    end
    return crc;
  endfunction

  // Binary search with floor midpoints over the active part of the table.
  // An unsorted table simply yields whatever this probe sequence meets.
  function automatic rsp_t lookup_name(logic [31:0] h);
    rsp_t r;
    int   lo;
    int   hi;
    int   mid;
    r.found = 1'b0;
    r.match_index = '0;
    r.name_hash = h;
    lo = 0;
    // A count above the table depth is clipped to the depth.
    hi = ((live_count > DEPTH) ? DEPTH : int'(live_count)) - 1;
    while (lo <= hi && !r.found) begin
      mid = (lo + hi) / 2;
      if (hash_image[mid] == h) begin
        r.found = 1'b1;
        r.match_index = mid[9:0];
      end else if (hash_image[mid] < h) begin
        lo = mid + 1;
      end else begin
        hi = mid - 1;
      end
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: offers queued items on the request channel and register writes
  // on the configuration channel, and updates the prediction on acceptance.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      req_if.valid <= 1'b0;
      cfg_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        case (req_if.payload.mode)
          MODE_WRITE: begin
            hash_image[req_if.payload.entry_index] = req_if.payload.entry_hash;
          end
          MODE_BYTE: begin
            // A NUL cannot be part of a name and leaves the CRC alone.
            if (req_if.payload.name_byte != 8'd0) begin
              path_crc = fold_path_byte(path_crc, req_if.payload.name_byte);
            end
          end
          MODE_SEARCH: begin
            lookup_q.push_back(lookup_name(~path_crc));
            path_crc = CRC_INIT;
          end
          default: begin
          end
        endcase
      end
      if (cfg_if.valid && cfg_if.ready) begin
        live_count = cfg_if.payload;
      end

      // A pending item stays on the channel until it is taken.
      if (!req_if.valid || req_if.ready) begin
        if (item_q.size() > 0 && int'($urandom_range(99)) >= sender_idle_pct) begin
          req_if.payload <= item_q.pop_front();
          req_if.valid <= 1'b1;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
      if (!cfg_if.valid || cfg_if.ready) begin
        if (count_q.size() > 0) begin
          cfg_if.payload <= count_q.pop_front();
          cfg_if.valid <= 1'b1;
        end else begin
          cfg_if.valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", field, want, got);
      fails++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Monitor: takes lookup results, compares them with the oldest prediction
  // and throttles the result channel, including the long hold-off.
  // --------------------------------------------------------------------------
  int hold_seen = 0;
  int hold_left = 0;

  always @(posedge clk) begin
    rsp_t want;
    logic take;
    if (rst) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (lookup_q.size() == 0) begin
          $error("lookup result with none outstanding: hash %h",
                 rsp_if.payload.name_hash);
          fails++;
        end else begin
          want = lookup_q.pop_front();
          check_field("found", 32'(want.found), 32'(rsp_if.payload.found));
          check_field("match_index", 32'(want.match_index),
                      32'(rsp_if.payload.match_index));
          check_field("name_hash", want.name_hash, rsp_if.payload.name_hash);
        end
      end
      if (hold_seen != hold_order) begin
        hold_seen = hold_order;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        take = 1'b0;
      end else begin
        take = int'($urandom_range(99)) >= recv_idle_pct;
      end
      rsp_if.ready <= take;
    end
  end

  // Watchdog: ends the run if nothing at all is accepted for too long.
  int stall_cycles = 0;

  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("path_hash_table_search: mismatch");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers. They run at falling edges only.
  // --------------------------------------------------------------------------
  task automatic queue_item(logic [1:0] mode, logic [9:0] idx, logic [31:0] h,
                            logic [7:0] b);
    req_t it;
    it.mode = mode;
    it.entry_index = idx;
    it.entry_hash = h;
    it.name_byte = b;
    item_q.push_back(it);
    if (mode != MODE_NONE) begin
      setting_items++;
    end
  endtask

  // Path characters weighted toward the cases the normalization cares about.
  function automatic logic [7:0] rand_path_byte();
    int pick;
    pick = $urandom_range(99);
    if (pick < 15) return UPPER_FIRST + 8'($urandom_range(25));
    if (pick < 40) return 8'h61 + 8'($urandom_range(25));
    if (pick < 50) return NAME_SLASH;
    if (pick < 58) return NAME_BACKSLASH;
    if (pick < 75) return HIGH_BYTES + 8'($urandom_range(127));
    if (pick < 80) return 8'h00;
    return 8'($urandom_range(1, 127));
  endfunction

  // Creates a random path name, mostly short, sometimes empty or long, and
  // records it with its hash. Returns its number in the name store.
  function automatic int make_name();
    int          len;
    int          pick;
    logic [31:0] crc;
    logic [7:0]  b;
    pick = $urandom_range(9);
    len = (pick == 0) ? 0 : (pick == 9) ? $urandom_range(9, 24) : $urandom_range(1, 8);
    crc = CRC_INIT;
    name_at.push_back(name_bytes.size());
    name_len.push_back(len);
    repeat (len) begin
      b = rand_path_byte();
      name_bytes.push_back(b);
      if (b != 8'd0) begin
        crc = fold_path_byte(crc, b);
      end
    end
    name_sum.push_back(~crc);
    return name_at.size() - 1;
  endfunction

  // One well-formed name: its bytes followed by the end-of-name item.
  task automatic queue_lookup(int k);
    for (int j = 0; j < name_len[k]; j++) begin
      queue_item(MODE_BYTE, 10'($urandom), $urandom, name_bytes[name_at[k] + j]);
    end
    queue_item(MODE_SEARCH, 10'($urandom), $urandom, 8'($urandom));
  endtask

  // Holds the sequence until every item has been taken, every lookup result
  // has come back and the block has had time to finish a byte item.
  task automatic wait_idle();
    do begin
      @(negedge clk);
    end while (item_q.size() != 0 || req_if.valid || lookup_q.size() != 0 ||
               count_q.size() != 0 || cfg_if.valid);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // The register is only written while the block is idle, and the next item
  // is not offered before the write has gone through.
  task automatic set_count(count_t value);
    wait_idle();
    count_q.push_back(value);
    wait_idle();
  endtask

  // Fills entries 0 .. n-1 with a mix of name hashes and random values,
  // sorted unless an unsorted table is asked for, written up or down.
  task automatic build_table(int n, bit in_order);
    logic [31:0] vals[$];
    bit          down;
    int          j;
    name_bytes.delete();
    name_at.delete();
    name_len.delete();
    name_sum.delete();
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(1) == 1) begin
        vals.push_back(name_sum[make_name()]);
      end else begin
        vals.push_back($urandom);
      end
    end
    if (in_order) begin
      vals.sort();
    end
    down = $urandom_range(1);
    for (int k = 0; k < n; k++) begin
      j = down ? n - 1 - k : k;
      queue_item(MODE_WRITE, 10'(j), vals[j], 8'($urandom));
    end
    if (n > written_top) begin
      written_top = n;
    end
  endtask

  // Mostly lookups of names held in the table, then misses, and a little
  // noise: idle mode items, dangling bytes that run into the next name, and
  // stray table writes.
  task automatic run_lookups(int cnt);
    int pick;
    for (int k = 0; k < cnt; k++) begin
      pick = $urandom_range(99);
      if (pick < 65 && name_at.size() > 0) begin
        queue_lookup(int'($urandom_range(name_at.size() - 1)));
      end else if (pick < 85) begin
        queue_lookup(make_name());
      end else if (pick < 92) begin
        queue_item(MODE_NONE, 10'($urandom), $urandom, 8'($urandom));
      end else if (pick < 96) begin
        repeat ($urandom_range(1, 3)) begin
          queue_item(MODE_BYTE, 10'($urandom), $urandom, rand_path_byte());
        end
      end else begin
        queue_item(MODE_WRITE, 10'($urandom), $urandom, 8'($urandom));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  initial begin
    int     n;
    int     k;
    int     pick;
    count_t cnt;

    req_if.valid = 1'b0;
    req_if.payload = '0;
    cfg_if.valid = 1'b0;
    cfg_if.payload = '0;
    rsp_if.ready = 1'b0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part. With an empty table every search misses; the empty
    // name hashes to zero.
    set_count('0);
    queue_item(MODE_SEARCH, 10'($urandom), $urandom, 8'($urandom));
    queue_item(MODE_NONE, 10'($urandom), $urandom, 8'($urandom));
    foreach (corner_bytes[i]) begin
      queue_item(MODE_BYTE, 10'($urandom), $urandom, corner_bytes[i]);
    end
    queue_item(MODE_SEARCH, 10'($urandom), $urandom, 8'($urandom));
    // Extremes of slot and hash; entry 0 is then overwritten with a name.
    queue_item(MODE_WRITE, 10'h3FF, 32'h0000_0000, 8'($urandom));
    queue_item(MODE_WRITE, 10'h000, 32'hFFFF_FFFF, 8'($urandom));
    k = make_name();
    queue_item(MODE_WRITE, 10'h000, name_sum[k], 8'($urandom));
    written_top = 1;
    set_count(count_t'(1));
    queue_lookup(k);
    queue_item(MODE_SEARCH, 10'($urandom), $urandom, 8'($urandom));

    // Random part, under three idling settings in turn.
    for (int s = 0; s < 3; s++) begin
      case (s)
        0: begin
          sender_idle_pct = 20;
          recv_idle_pct = 88;
        end
        1: begin
          sender_idle_pct = 88;
          recv_idle_pct = 20;
        end
        default: begin
          sender_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase

      if (s == 1) begin
        // Full table, searched with a count past the depth and at the depth.
        build_table(DEPTH, 1'b1);
        set_count(COUNT_MAX);
        run_lookups(12);
        set_count(count_t'(DEPTH));
        run_lookups(12);
      end
      if (s == 2) begin
        // The receiver holds off while a burst of lookups is offered, so the
        // block fills up and stalls its input. Then the sender waits until
        // every result is back.
        build_table(16, 1'b1);
        set_count(count_t'(16));
        hold_order++;
        for (int j = 0; j < 30; j++) begin
          queue_lookup(int'($urandom_range(name_at.size() - 1)));
        end
        wait_idle();
      end

      setting_items = 0;
      while (setting_items < SETTING_ITEMS) begin
        pick = $urandom_range(19);
        n = (pick == 0) ? 0 : (pick < 4) ? $urandom_range(25, 200) : $urandom_range(1, 24);
        build_table(n, $urandom_range(7) != 0);
        cnt = count_t'(n);
        if ($urandom_range(4) == 0) begin
          cnt = count_t'($urandom_range((written_top == DEPTH) ? COUNT_MAX : written_top));
        end
        set_count(cnt);
        run_lookups($urandom_range(8, 20));
      end
    end

    wait_idle();
    if (fails == 0) begin
      $display("path_hash_table_search: match");
    end else begin
      $display("path_hash_table_search: mismatch");
    end
    $finish;
  end

endmodule
